### rtl/bjfk_pkg.sv
// ----------------------------------------------------------------------------
// bjfk_pkg
// shared constants, types and arithmetic helpers for the ball joint forward
// kinematics block
// ----------------------------------------------------------------------------
package bjfk_pkg;

    // angle units: 2^-15 degree
    localparam int HALF_TURN_DEG = 180;
    localparam int DEG_UNIT      = 32768;

    localparam logic [23:0] HALF_TURN    = 24'(HALF_TURN_DEG * DEG_UNIT);
    localparam logic [23:0] QUARTER_TURN = 24'(HALF_TURN_DEG / 2 * DEG_UNIT);
    localparam logic [23:0] EIGHTH_TURN  = 24'(HALF_TURN_DEG / 4 * DEG_UNIT);

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [32:0] PI_Q30  = 33'd3373259426;

    // divide / square root unit sizes
    localparam int DSU_DW        = 54;
    localparam int DSU_QW        = 31;
    localparam int DSU_VW        = 24;
    localparam int DSU_RW        = 26;
    localparam int DIV_STEPS     = 31;
    localparam int SQRT_STEPS    = 24;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_dsu_ctl;

    typedef struct packed {
        logic done;
    } t_dsu_sts;

    // q2.30 product rounding, ties away from zero
    function automatic logic signed [35:0] f_rnd30(input logic signed [67:0] p);
        logic [67:0] t;
        t = p + 68'd536870912 - {67'b0, p[67]};
        return t[65:30];
    endfunction

    // q10.38 to q16.16 rounding, ties away from zero
    function automatic logic signed [35:0] f_rnd22(input logic signed [67:0] p);
        logic [67:0] t;
        t = p + 68'd2097152 - {67'b0, p[67]};
        return t[57:22];
    endfunction

    // saturate to 32-bit signed
    function automatic logic signed [31:0] f_sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // taylor factorial factors, sine then cosine series
    function automatic logic [7:0] f_fac(input logic is_cos, input logic [2:0] k);
        logic [7:0] r;
        unique case ({is_cos, k})
            4'b0_001: r = 8'd6;
            4'b0_010: r = 8'd20;
            4'b0_011: r = 8'd42;
            4'b0_100: r = 8'd72;
            4'b0_101: r = 8'd110;
            4'b1_001: r = 8'd2;
            4'b1_010: r = 8'd12;
            4'b1_011: r = 8'd30;
            4'b1_100: r = 8'd56;
            4'b1_101: r = 8'd90;
            4'b1_110: r = 8'd132;
            default:  r = 8'd1;
        endcase
        return r;
    endfunction

    // cross product matrix entry of the unit axis
    function automatic logic signed [31:0] f_kent(
        input logic [1:0]        row,
        input logic [1:0]        col,
        input logic signed [31:0] u0,
        input logic signed [31:0] u1,
        input logic signed [31:0] u2
    );
        logic signed [31:0] r;
        unique case ({row, col})
            4'b00_01: r = -u2;
            4'b00_10: r = u1;
            4'b01_00: r = u2;
            4'b01_10: r = -u0;
            4'b10_00: r = -u1;
            4'b10_01: r = u0;
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/bjfk_if.sv
// ----------------------------------------------------------------------------
// bjfk_if
// link request and position result channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface bjfk_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        link_length;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               last_link;

    modport source (output valid, output link_length, output rot_x, output rot_y,
                    output rot_z, output last_link, input ready);
    modport sink   (input valid, input link_length, input rot_x, input rot_y,
                    input rot_z, input last_link, output ready);
endinterface

interface bjfk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               is_end;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output is_end, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input is_end, output ready);
endinterface

### rtl/ball_joint_forward_kinematics.sv
// ----------------------------------------------------------------------------
// ball_joint_forward_kinematics
// per-link rodrigues rotation, accumulated rotation and end position
// ----------------------------------------------------------------------------
//   channel   dir   handshake     payload
//   i_link    in    valid/ready   link_length, rot_x, rot_y, rot_z, last_link
//   o_pos     out   valid/ready   pos_x, pos_y, pos_z, is_end
//
// each request is carried through to its result before the next one is accepted;
// the time taken depends on the number of quarter turns removed from the angle,
// and a zero rotation vector goes straight to the position step. the work runs on
// the shared divide/sqrt unit (one bit per cycle: the angle sqrt, then 15 divides)
// and the shared 34x34 multiplier, each product formed and then rounded and
// accumulated, for the 3x3 matrix work.
// reset (synchronous, active low) loads identity rotation and zero position.
// a result waiting on o_pos does not block the next request; only the next
// result waits in its last cycle until the output register is free.
// ----------------------------------------------------------------------------
module ball_joint_forward_kinematics import bjfk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bjfk_in_if.sink      i_link,
    bjfk_out_if.source   o_pos
);

    typedef enum logic [3:0] {
        S_IDLE, S_N2, S_SQRT, S_RED, S_XMUL, S_XDIV, S_X2, S_TMUL,
        S_TDIV, S_SCFIN, S_QMAP, S_AXIS, S_ROD, S_MAT, S_POS, S_OUT
    } t_state;

    t_state              r_state;
    logic                r_ph;
    logic [2:0]          r_k;
    logic [1:0]          r_i;
    logic [1:0]          r_j;
    logic [2:0]          r_m;
    logic                r_cos;
    logic                r_swap;
    logic [1:0]          r_quad;

    logic [15:0]         r_len;
    logic signed [15:0]  r_rv [3];
    logic                r_last;

    logic [31:0]         r_n2;
    logic [23:0]         r_mag;
    logic [23:0]         r_ang;
    logic [30:0]         r_x;
    logic [29:0]         r_x2;
    logic [30:0]         r_term;
    logic signed [35:0]  r_acc;
    logic [30:0]         r_s0;
    logic [30:0]         r_c0;
    logic signed [31:0]  r_s;
    logic signed [31:0]  r_c;
    logic signed [31:0]  r_u [3];
    logic signed [35:0]  r_k2;
    logic signed [31:0]  r_r [9];
    logic signed [31:0]  r_row [2];
    logic signed [31:0]  r_rot [9];
    logic signed [31:0]  r_pos [3];
    logic signed [67:0]  r_prod;

    logic                r_ov;
    logic signed [31:0]  r_ox;
    logic signed [31:0]  r_oy;
    logic signed [31:0]  r_oz;
    logic                r_oend;

    logic signed [33:0]  w_ma;
    logic signed [33:0]  w_mb;
    logic                w_mul_en;
    logic signed [35:0]  w_r30;
    logic signed [35:0]  w_sum;
    logic signed [35:0]  w_r22;
    logic [31:0]         w_n2n;
    logic [15:0]         w_absr;
    logic [30:0]         w_uq;
    logic [30:0]         w_clamp;
    logic signed [31:0]  w_sr;
    logic signed [31:0]  w_cr;
    logic signed [33:0]  w_t1;
    logic [3:0]          w_rij;
    logic [3:0]          w_rim;
    logic [3:0]          w_rmj;
    logic [3:0]          w_rk1;
    logic signed [31:0]  w_kij;
    logic signed [31:0]  w_sat;

    t_dsu_ctl            w_dctl;
    t_dsu_sts            w_dsts;
    logic [DSU_DW-1:0]   w_dividend;
    logic [DSU_VW-1:0]   w_divisor;
    logic [DSU_QW-1:0]   w_dres;

    bjfk_dsu u_dsu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_dsts),
        .o_res      (w_dres)
    );

    // index arithmetic for the 3x3 arrays
    assign w_rij = 4'({2'b0, r_i} * 4'd3 + {2'b0, r_j});
    assign w_rim = 4'({2'b0, r_i} * 4'd3 + {2'b0, r_m[1:0]});
    assign w_rmj = 4'({2'b0, r_m[1:0]} * 4'd3 + {2'b0, r_j});
    assign w_rk1 = 4'({2'b0, r_k[1:0]} * 4'd3 + 4'd1);
    assign w_kij = f_kent(r_i, r_j, r_u[0], r_u[1], r_u[2]);
    assign w_t1  = 34'sd1073741824 - 34'(r_c);

    // rounded product and running sums
    assign w_r30 = f_rnd30(r_prod);
    assign w_r22 = f_rnd22(r_prod);
    assign w_sum = r_acc + w_r30;
    assign w_sat = f_sat32(w_sum);
    assign w_n2n = r_n2 + r_prod[31:0];

    // axis component magnitude, quotient clamp, series clamp
    assign w_absr  = r_rv[r_k[1:0]][15] ? 16'(-r_rv[r_k[1:0]]) : 16'(r_rv[r_k[1:0]]);
    assign w_uq    = (w_dres > ONE_Q30) ? ONE_Q30 : w_dres;
    assign w_clamp = (r_acc < 36'sd0) ? 31'd0 :
                     (r_acc > 36'(ONE_Q30)) ? ONE_Q30 : r_acc[30:0];

    // octant fold back
    assign w_sr = r_swap ? 32'({1'b0, r_c0}) : 32'({1'b0, r_s0});
    assign w_cr = r_swap ? 32'({1'b0, r_s0}) : 32'({1'b0, r_c0});

    // shared multiplier operand select
    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_mul_en = 1'b0;
        unique case (r_state)
            S_N2: begin
                w_ma     = 34'(r_rv[r_k[1:0]]);
                w_mb     = 34'(r_rv[r_k[1:0]]);
                w_mul_en = !r_ph;
            end
            S_XMUL: begin
                w_ma     = {10'b0, r_ang};
                w_mb     = {1'b0, PI_Q30};
                w_mul_en = !r_ph;
            end
            S_X2: begin
                w_ma     = {3'b0, r_x};
                w_mb     = {3'b0, r_x};
                w_mul_en = !r_ph;
            end
            S_TMUL: begin
                w_ma     = {3'b0, r_term};
                w_mb     = {4'b0, r_x2};
                w_mul_en = !r_ph;
            end
            S_ROD: begin
                priority if (r_m < 3'd3) begin
                    w_ma = 34'(f_kent(r_i, r_m[1:0], r_u[0], r_u[1], r_u[2]));
                    w_mb = 34'(f_kent(r_m[1:0], r_j, r_u[0], r_u[1], r_u[2]));
                end else if (r_m == 3'd3) begin
                    w_ma = 34'(r_s);
                    w_mb = 34'(w_kij);
                end else begin
                    w_ma = w_t1;
                    w_mb = 34'(r_k2);
                end
                w_mul_en = !r_ph;
            end
            S_MAT: begin
                w_ma     = 34'(r_rot[w_rim]);
                w_mb     = 34'(r_r[w_rmj]);
                w_mul_en = !r_ph;
            end
            S_POS: begin
                w_ma     = {18'b0, r_len};
                w_mb     = 34'(r_rot[w_rk1]);
                w_mul_en = !r_ph;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    // divide/sqrt unit request select
    always_comb begin
        w_dctl     = '0;
        w_dividend = '0;
        w_divisor  = '0;
        unique case (r_state)
            S_SQRT: begin
                w_dctl.start = !r_ph;
                w_dctl.sqrt  = 1'b1;
                w_dividend   = {r_n2, 22'b0};
            end
            S_XDIV: begin
                w_dctl.start = !r_ph;
                w_dividend   = r_prod[DSU_DW-1:0];
                w_divisor    = HALF_TURN;
            end
            S_TDIV: begin
                w_dctl.start = !r_ph;
                w_dividend   = {24'b0, r_prod[59:30]};
                w_divisor    = {16'b0, f_fac(r_cos, r_k)};
            end
            S_AXIS: begin
                w_dctl.start = !r_ph;
                w_dividend   = {w_absr, 38'b0};
                w_divisor    = r_mag;
            end
            default: begin
                w_dctl.start = 1'b0;
            end
        endcase
    end

    // shared multiplier product register
    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_ma * w_mb;
        end
    end

    // sequencer, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_ov    <= 1'b0;
            for (int n = 0; n < 9; n++) begin
                r_rot[n] <= (n % 4 == 0) ? 32'({1'b0, ONE_Q30}) : 32'sd0;
            end
            for (int n = 0; n < 3; n++) begin
                r_pos[n] <= '0;
            end
        end else begin
            if (o_pos.valid && o_pos.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_link.valid) begin
                        r_len   <= i_link.link_length;
                        r_rv[0] <= i_link.rot_x;
                        r_rv[1] <= i_link.rot_y;
                        r_rv[2] <= i_link.rot_z;
                        r_last  <= i_link.last_link;
                        r_n2    <= '0;
                        r_k     <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_N2;
                    end
                end
                // squared rotation vector length
                S_N2: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_n2 <= w_n2n;
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_state <= (w_n2n == 32'd0) ? S_POS : S_SQRT;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                // angle magnitude
                S_SQRT: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_dsts.done) begin
                        r_mag   <= w_dres[23:0];
                        r_ang   <= w_dres[23:0];
                        r_quad  <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_RED;
                    end
                end
                // quadrant reduction and octant fold
                S_RED: begin
                    if (r_ang >= QUARTER_TURN) begin
                        r_ang  <= r_ang - QUARTER_TURN;
                        r_quad <= r_quad + 2'd1;
                    end else begin
                        r_swap <= r_ang > EIGHTH_TURN;
                        if (r_ang > EIGHTH_TURN) begin
                            r_ang <= QUARTER_TURN - r_ang;
                        end
                        r_state <= S_XMUL;
                    end
                end
                S_XMUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_state <= S_XDIV;
                    end
                end
                // degrees to radians
                S_XDIV: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_dsts.done) begin
                        r_x     <= w_dres;
                        r_ph    <= 1'b0;
                        r_state <= S_X2;
                    end
                end
                S_X2: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_x2    <= r_prod[59:30];
                        r_term  <= r_x;
                        r_acc   <= 36'({1'b0, r_x});
                        r_k     <= 3'd1;
                        r_cos   <= 1'b0;
                        r_state <= S_TMUL;
                    end
                end
                // taylor term times x^2
                S_TMUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_state <= S_TDIV;
                    end
                end
                // term over factorial factors, alternating sum
                S_TDIV: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_dsts.done) begin
                        r_term <= w_dres;
                        r_acc  <= r_k[0] ? r_acc - 36'({1'b0, w_dres})
                                         : r_acc + 36'({1'b0, w_dres});
                        r_ph   <= 1'b0;
                        if (r_k == (r_cos ? 3'd6 : 3'd5)) begin
                            r_state <= S_SCFIN;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_SCFIN: begin
                    if (!r_cos) begin
                        r_s0    <= w_clamp;
                        r_term  <= ONE_Q30;
                        r_acc   <= 36'({1'b0, ONE_Q30});
                        r_k     <= 3'd1;
                        r_cos   <= 1'b1;
                        r_state <= S_TMUL;
                    end else begin
                        r_c0    <= w_clamp;
                        r_state <= S_QMAP;
                    end
                end
                // quadrant signs
                S_QMAP: begin
                    unique case (r_quad)
                        2'd0: begin r_s <= w_sr;  r_c <= w_cr;  end
                        2'd1: begin r_s <= w_cr;  r_c <= -w_sr; end
                        2'd2: begin r_s <= -w_sr; r_c <= -w_cr; end
                        default: begin r_s <= -w_cr; r_c <= w_sr; end
                    endcase
                    r_k     <= '0;
                    r_ph    <= 1'b0;
                    r_state <= S_AXIS;
                end
                // unit axis components
                S_AXIS: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_dsts.done) begin
                        r_u[r_k[1:0]] <= r_rv[r_k[1:0]][15] ? -32'({1'b0, w_uq})
                                                            : 32'({1'b0, w_uq});
                        r_ph <= 1'b0;
                        if (r_k == 3'd2) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_m     <= '0;
                            r_acc   <= '0;
                            r_state <= S_ROD;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                // rodrigues matrix, five products per entry
                S_ROD: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        priority if (r_m < 3'd2) begin
                            r_acc <= w_sum;
                            r_m   <= r_m + 3'd1;
                        end else if (r_m == 3'd2) begin
                            r_k2  <= w_sum;
                            r_acc <= (r_i == r_j) ? 36'({1'b0, ONE_Q30}) : 36'sd0;
                            r_m   <= 3'd3;
                        end else if (r_m == 3'd3) begin
                            r_acc <= w_sum;
                            r_m   <= 3'd4;
                        end else begin
                            r_r[w_rij] <= w_sat;
                            r_acc      <= '0;
                            r_m        <= '0;
                            if (r_j == 2'd2) begin
                                r_j <= '0;
                                if (r_i == 2'd2) begin
                                    r_i     <= '0;
                                    r_state <= S_MAT;
                                end else begin
                                    r_i <= r_i + 2'd1;
                                end
                            end else begin
                                r_j <= r_j + 2'd1;
                            end
                        end
                    end
                end
                // accumulated rotation times rodrigues matrix, row by row
                S_MAT: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_m < 3'd2) begin
                            r_acc <= w_sum;
                            r_m   <= r_m + 3'd1;
                        end else begin
                            r_acc <= '0;
                            r_m   <= '0;
                            if (r_j == 2'd2) begin
                                r_rot[w_rij - 4'd2] <= r_row[0];
                                r_rot[w_rij - 4'd1] <= r_row[1];
                                r_rot[w_rij]        <= w_sat;
                                r_j                 <= '0;
                                if (r_i == 2'd2) begin
                                    r_i     <= '0;
                                    r_k     <= '0;
                                    r_state <= S_POS;
                                end else begin
                                    r_i <= r_i + 2'd1;
                                end
                            end else begin
                                r_row[r_j[0]] <= w_sat;
                                r_j           <= r_j + 2'd1;
                            end
                        end
                    end
                end
                // position step along the second column
                S_POS: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_pos[r_k[1:0]] <= f_sat32(36'(r_pos[r_k[1:0]]) + w_r22);
                        if (r_k == 3'd2) begin
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                // hand result to the output register
                S_OUT: begin
                    if (!r_ov || o_pos.ready) begin
                        r_ov   <= 1'b1;
                        r_ox   <= r_pos[0];
                        r_oy   <= r_pos[1];
                        r_oz   <= r_pos[2];
                        r_oend <= r_last;
                        if (r_last) begin
                            for (int n = 0; n < 9; n++) begin
                                r_rot[n] <= (n % 4 == 0) ? 32'({1'b0, ONE_Q30}) : 32'sd0;
                            end
                            for (int n = 0; n < 3; n++) begin
                                r_pos[n] <= '0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign i_link.ready = (r_state == S_IDLE);
    assign o_pos.valid  = r_ov;
    assign o_pos.pos_x  = r_ox;
    assign o_pos.pos_y  = r_oy;
    assign o_pos.pos_z  = r_oz;
    assign o_pos.is_end = r_oend;

endmodule

### rtl/bjfk_dsu.sv
// ----------------------------------------------------------------------------
// bjfk_dsu
// iterative restoring divider and integer square root, one bit per cycle
// ----------------------------------------------------------------------------
module bjfk_dsu import bjfk_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dsu_ctl            i_ctl,
    input  logic [DSU_DW-1:0]   i_dividend,
    input  logic [DSU_VW-1:0]   i_divisor,
    output t_dsu_sts            o_sts,
    output logic [DSU_QW-1:0]   o_res
);

    logic                r_busy;
    logic                r_sqrt;
    logic                r_done;
    logic [4:0]          r_cnt;
    logic [DSU_RW-1:0]   r_rem;
    logic [DSU_DW-1:0]   r_lo;
    logic [DSU_QW-1:0]   r_q;
    logic [DSU_VW-1:0]   r_dvs;

    logic [DSU_RW-1:0]   w_td;
    logic                w_dge;
    logic [DSU_RW+1:0]   w_ts;
    logic [DSU_RW+1:0]   w_trial;
    logic                w_sge;

    // divide: shift one dividend bit in; sqrt: two radicand bits against 4*root+1
    assign w_td    = {r_rem[DSU_RW-2:0], r_lo[DSU_DW-1]};
    assign w_dge   = w_td >= {2'b0, r_dvs};
    assign w_ts    = {r_rem, r_lo[DSU_DW-1 -: 2]};
    assign w_trial = {2'b0, r_q[DSU_VW-1:0], 2'b01};
    assign w_sge   = w_ts >= w_trial;

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_ctl.sqrt;
                r_dvs  <= i_divisor;
                r_q    <= '0;
                if (i_ctl.sqrt) begin
                    r_cnt <= 5'(SQRT_STEPS - 1);
                    r_rem <= '0;
                    r_lo  <= i_dividend;
                end else begin
                    r_cnt <= 5'(DIV_STEPS - 1);
                    r_rem <= DSU_RW'(i_dividend[DSU_DW-1:DIV_STEPS]);
                    r_lo  <= {i_dividend[DIV_STEPS-1:0], (DSU_DW - DIV_STEPS)'(0)};
                end
            end else if (r_busy) begin
                if (r_sqrt) begin
                    if (w_sge) begin
                        r_rem <= DSU_RW'(w_ts - w_trial);
                        r_q   <= {r_q[DSU_QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_ts[DSU_RW-1:0];
                        r_q   <= {r_q[DSU_QW-2:0], 1'b0};
                    end
                    r_lo <= {r_lo[DSU_DW-3:0], 2'b00};
                end else begin
                    if (w_dge) begin
                        r_rem <= w_td - {2'b0, r_dvs};
                        r_q   <= {r_q[DSU_QW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_td;
                        r_q   <= {r_q[DSU_QW-2:0], 1'b0};
                    end
                    r_lo <= {r_lo[DSU_DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_res      = r_q;

endmodule

### bench/bjfk_scoreboard.sv
// ----------------------------------------------------------------------------
// bjfk_scoreboard
// watches the link and position channels, predicts each end position from
// the accepted link requests and compares results in order
// ----------------------------------------------------------------------------
module bjfk_scoreboard (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bjfk_in_if    link,
    bjfk_out_if   pos,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE      = 64'sd1 << 30;
    localparam longint PI_FIX   = 64'sd3373259426;
    localparam longint UNIT_DEG = 32768;
    localparam longint FULL     = 360 * UNIT_DEG;
    localparam longint QUARTER  = 90 * UNIT_DEG;
    localparam longint EIGHTH   = 45 * UNIT_DEG;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               is_end;
    } t_pos;

    longint rot_acc [9];
    longint pos_acc [3];
    t_pos   pos_expected [$];
    int     fail_count = 0;

    assign o_fail_count = fail_count;

    // round to nearest, ties away from zero
    function automatic longint rnd_shift(input longint p, input int n);
        longint unsigned m;
        m = (p < 0) ? longint'(-p) : longint'(p);
        m = (m + (64'd1 << (n - 1))) >> n;
        return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    // taylor sine and cosine over the first octant
    task automatic octant_trig(input longint unsigned a, output longint s, output longint c);
        longint unsigned x, x2, term;
        longint sum;
        x = (a * longint'(PI_FIX)) / (180 * 64'd32768);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            sum = (k % 2) ? sum - longint'(term) : sum + longint'(term);
        end
        s = (sum < 0) ? 0 : (sum > ONE) ? ONE : sum;
        term = ONE;
        sum = ONE;
        for (int k = 1; k <= 6; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            sum = (k % 2) ? sum - longint'(term) : sum + longint'(term);
        end
        c = (sum < 0) ? 0 : (sum > ONE) ? ONE : sum;
    endtask

    // quadrant and octant folding
    task automatic angle_trig(input longint unsigned ang, output longint s, output longint c);
        longint unsigned a, q, rem;
        longint s0, c0, sr, cr;
        a = ang % FULL;
        q = a / QUARTER;
        rem = a % QUARTER;
        if (rem > EIGHTH) begin
            octant_trig(QUARTER - rem, s0, c0);
            sr = c0;
            cr = s0;
        end else begin
            octant_trig(rem, s0, c0);
            sr = s0;
            cr = c0;
        end
        case (q)
            0: begin s = sr;  c = cr;  end
            1: begin s = cr;  c = -sr; end
            2: begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr; end
        endcase
    endtask

    // one link: rotate, advance along local y, emit position
    task automatic advance_link(input logic [15:0] len_in, input logic signed [15:0] rx,
                                input logic signed [15:0] ry, input logic signed [15:0] rz,
                                input logic last, output t_pos p);
        longint r [3];
        longint u [3];
        longint skew [9];
        longint rod [9];
        longint nrot [9];
        longint unsigned n2, mag, m, q;
        longint s, c, t1, k2, v, len, d;
        r[0] = rx;
        r[1] = ry;
        r[2] = rz;
        len = len_in;
        n2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        if (n2 != 0) begin
            mag = int_sqrt(n2 << 16);
            for (int i = 0; i < 3; i++) begin
                m = (r[i] < 0) ? -r[i] : r[i];
                q = (m << 38) / mag;
                if (q > ONE) q = ONE;
                u[i] = (r[i] < 0) ? -longint'(q) : longint'(q);
            end
            skew = '{0, -u[2], u[1], u[2], 0, -u[0], -u[1], u[0], 0};
            angle_trig(mag, s, c);
            t1 = ONE - c;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    k2 = 0;
                    for (int k = 0; k < 3; k++) k2 += mul_q30(skew[i*3+k], skew[k*3+j]);
                    v = ((i == j) ? ONE : 0) + mul_q30(s, skew[i*3+j]) + mul_q30(t1, k2);
                    rod[i*3+j] = clamp32(v);
                end
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v = 0;
                    for (int k = 0; k < 3; k++) v += mul_q30(rot_acc[i*3+k], rod[k*3+j]);
                    nrot[i*3+j] = clamp32(v);
                end
            end
            rot_acc = nrot;
        end
        for (int i = 0; i < 3; i++) begin
            d = rnd_shift(len * rot_acc[i*3+1], 22);
            pos_acc[i] = clamp32(pos_acc[i] + d);
        end
        p.x = pos_acc[0][31:0];
        p.y = pos_acc[1][31:0];
        p.z = pos_acc[2][31:0];
        p.is_end = last;
        if (last) chain_home();
    endtask

    task automatic chain_home();
        for (int i = 0; i < 9; i++) rot_acc[i] = (i % 4 == 0) ? ONE : 0;
        for (int i = 0; i < 3; i++) pos_acc[i] = 0;
    endtask

    // predict on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_pos p, e;
        if (!i_rst_n) begin
            chain_home();
            pos_expected.delete();
        end else begin
            if (link.valid && link.ready) begin
                advance_link(link.link_length, link.rot_x, link.rot_y, link.rot_z,
                             link.last_link, p);
                pos_expected.push_back(p);
            end
            if (pos.valid && pos.ready) begin
                if (pos_expected.size() == 0) begin
                    $error("unexpected position result");
                    fail_count++;
                end else begin
                    e = pos_expected.pop_front();
                    if (pos.pos_x !== e.x) begin
                        $error("pos_x expected %0d actual %0d", e.x, pos.pos_x);
                        fail_count++;
                    end
                    if (pos.pos_y !== e.y) begin
                        $error("pos_y expected %0d actual %0d", e.y, pos.pos_y);
                        fail_count++;
                    end
                    if (pos.pos_z !== e.z) begin
                        $error("pos_z expected %0d actual %0d", e.z, pos.pos_z);
                        fail_count++;
                    end
                    if (pos.is_end !== e.is_end) begin
                        $error("is_end expected %0d actual %0d", e.is_end, pos.is_end);
                        fail_count++;
                    end
                end
            end
        end
        o_pending = pos_expected.size();
    end

endmodule

### bench/tb_ball_joint_forward_kinematics.sv
// ----------------------------------------------------------------------------
// tb_ball_joint_forward_kinematics
// drives directed and random arm chains with random idling on both channels;
// the scoreboard predicts and checks every end position
// ----------------------------------------------------------------------------
module tb_ball_joint_forward_kinematics;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_LINKS = 1730;
    localparam int QUIET_LINKS  = 150;
    localparam logic signed [15:0] DEG_180  = 16'sd23040;
    localparam logic signed [15:0] DEG_90   = 16'sd11520;
    localparam logic signed [15:0] DEG_45   = 16'sd5760;
    // equal components whose vector length is just over a full turn
    localparam logic signed [15:0] DIAG_360 = 16'sd26605;

    logic i_clk;
    logic i_rst_n;
    logic gaps_on;
    int   fail_count;
    int   pending;
    int   stall_left = 0;
    int   run_left = 0;
    int   sent;

    bjfk_in_if  link_if ();
    bjfk_out_if pos_if ();

    ball_joint_forward_kinematics DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (link_if),
        .o_pos   (pos_if)
    );

    bjfk_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .link         (link_if),
        .pos          (pos_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!gaps_on) begin
            pos_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            pos_if.ready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            pos_if.ready <= 1'b1;
            run_left--;
        end else begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 14);
            else run_left = $urandom_range(1, 40);
            pos_if.ready <= 1'b1;
        end
    end

    // one link request, with an optional idle burst ahead of it
    task automatic send_link(input logic [15:0] len, input logic signed [15:0] rx,
                             input logic signed [15:0] ry, input logic signed [15:0] rz,
                             input logic last);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            link_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        link_if.link_length <= len;
        link_if.rot_x       <= rx;
        link_if.rot_y       <= ry;
        link_if.rot_z       <= rz;
        link_if.last_link   <= last;
        link_if.valid       <= 1'b1;
        @(posedge i_clk);
        while (!link_if.ready) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic signed [15:0] pick_rot(input int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'(int'($urandom_range(0, 4000)) - 2000);
            default: return ($urandom_range(0, 2) == 0) ? 16'sd0
                                                        : 16'(int'($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    // stimulus
    initial begin
        int mode;
        int chain_len;
        logic [15:0] len;
        bit drained;
        gaps_on = 1'b1;
        sent = 0;
        drained = 1'b0;
        link_if.valid = 1'b0;
        link_if.link_length = '0;
        link_if.rot_x = '0;
        link_if.rot_y = '0;
        link_if.rot_z = '0;
        link_if.last_link = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero rotation, length extremes
        send_link(16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_link(16'hffff, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        // quadrant and octant edges
        send_link(16'h0100, DEG_90, 16'sd0, 16'sd0, 1'b0);
        send_link(16'h0100, 16'sd0, DEG_45, 16'sd0, 1'b0);
        send_link(16'h0100, 16'sd0, 16'sd0, DEG_180, 1'b0);
        send_link(16'h0100, -DEG_180, 16'sd0, 16'sd0, 1'b1);
        send_link(16'h0200, DIAG_360, DIAG_360, DIAG_360, 1'b0);
        send_link(16'h0200, 16'sd5761, 16'sd0, 16'sd0, 1'b0);
        send_link(16'h0200, 16'sd0, 16'sd11521, 16'sd0, 1'b1);
        // field extremes, axis held at one
        send_link(16'hffff, 16'sh7fff, 16'sd0, 16'sd0, 1'b0);
        send_link(16'hffff, -16'sd32768, 16'sd0, 16'sd0, 1'b0);
        send_link(16'hffff, 16'sd0, -16'sd32768, 16'sd0, 1'b0);
        send_link(16'hffff, 16'sd0, 16'sd0, 16'sh7fff, 1'b0);
        send_link(16'hffff, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        send_link(16'hffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_link(16'h0001, 16'sd1, 16'sd0, 16'sd0, 1'b0);
        send_link(16'h8000, 16'sd1, -16'sd1, 16'sd1, 1'b1);
        // many small rotations so the matrix drifts
        for (int i = 0; i < 6; i++)
            send_link(16'h0080, 16'sd3, -16'sd2, 16'sd5, i == 5);

        // random chains, each closed by a last link, and single noise links of random fields
        while (sent < RANDOM_LINKS) begin
            if (RANDOM_LINKS - sent <= QUIET_LINKS) gaps_on = 1'b0;
            if (!drained && sent > RANDOM_LINKS / 2) begin
                // drain completely before the next chain
                drained = 1'b1;
                link_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            mode = $urandom_range(0, 9);
            if (mode == 9) begin
                // long straight chain at full length drives the position to saturate
                chain_len = $urandom_range(130, 160);
                for (int i = 0; i < chain_len; i++)
                    send_link(16'hffff, 16'sd0, 16'sd0,
                              (i == 0) ? pick_rot($urandom_range(0, 1)) : 16'sd0,
                              i == chain_len - 1);
            end else if (mode == 8) begin
                // noise: broken chain lengths, fully random fields
                send_link(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                          1'($urandom_range(0, 1)));
            end else begin
                chain_len = $urandom_range(1, 12);
                for (int i = 0; i < chain_len; i++) begin
                    len = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2048));
                    send_link(len, pick_rot(mode % 3), pick_rot(mode % 3), pick_rot(mode % 3),
                              i == chain_len - 1);
                end
            end
        end
        link_if.valid <= 1'b0;
        gaps_on = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
